>>> hw/rtl/orb_pkg.sv
// Shared types and constants of the overwriting ring buffer.
`default_nettype none

package orb_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CAP_W      = 5;
   localparam int BEAT_W     = 32;
   localparam int PEEK_W     = 4;
   localparam int MAX_DATA_W = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_PEEK  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [BEAT_W-1:0]   push_data;
      logic [PEEK_W-1:0]   peek_index;
   } req_type;

   typedef struct packed {
      logic [BEAT_W-1:0]   read_data;
      logic                read_ok;
      logic [CAP_W-1:0]    entry_count;
      logic                is_empty;
      logic                is_full;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic exec;
   } cmd_type;

endpackage

`default_nettype wire

>>> hw/rtl/orb_ctrl.sv
// Handshake controller of the overwriting ring buffer.
`default_nettype none

module orb_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output orb_pkg::cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      rsp_done;

   // A new beat may enter when no result waits or the waiting one leaves now.
   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign rsp_valid = (state_ff == ST_RESP);
   assign accept    = req_valid && req_ready;
   assign rsp_done  = rsp_valid && rsp_ready;

   assign cmd.exec = accept;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (accept) state_in = ST_RESP;
            else if (rsp_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/orb_dp.sv
// Pointers, entry memory and result registers of the overwriting ring buffer.
`default_nettype none

module orb_dp #(
   parameter int DEPTH      = orb_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = orb_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                           clock,
   input  wire                           reset,
   input  orb_pkg::cmd_type              cmd,
   input  orb_pkg::req_type              req,
   input  wire                           csr_we,
   input  wire [orb_pkg::CAP_W-1:0]      csr_wdata,
   output orb_pkg::rsp_type              rsp
);

   localparam int CW    = orb_pkg::CAP_W;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int MW    = orb_pkg::MAX_DATA_W;
   localparam int BW    = orb_pkg::BEAT_W;

   function automatic logic [CW-1:0] adv(input logic [CW-1:0] p, input logic [CW-1:0] c);
      logic [CW:0] n;
      n = {1'b0, p} + 1'b1;
      return (n >= {1'b0, c}) ? '0 : n[CW-1:0];
   endfunction

   function automatic logic [CW-1:0] held(input logic [CW-1:0] w, input logic [CW-1:0] r,
                                          input logic f, input logic [CW-1:0] c);
      logic [CW:0] s;
      s = {1'b0, w} + {1'b0, c} - {1'b0, r};
      if (f) return c;
      if (w >= r) return w - r;
      return s[CW-1:0];
   endfunction

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] mem_q_ff;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] rd_addr;
   logic             full_ff, full_in;
   logic [CW-1:0]    cap_ff;

   logic             ok_ff, ok_in;
   logic             sel_ff, sel_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             full_out_ff;

   logic [CW-1:0]    cap;
   logic [CW-1:0]    wr5, rd5, wr_n, rd_n, held_now, off5, peek5, rd_addr5;
   logic [CW:0]      peek_sum;
   logic             wr_en, rd_en;
   logic [MW-1:0]    push_wide;
   logic [MW-1:0]    rd_wide;

   // Clamp capacity to 1..DEPTH.
   always_comb begin
      if (cap_ff == '0) cap = CW'(1);
      else if (32'(cap_ff) > DEPTH) cap = CW'(DEPTH);
      else cap = cap_ff;
   end

   always_comb begin
      wr5      = CW'(wr_ptr_ff);
      rd5      = CW'(rd_ptr_ff);
      held_now = held(wr5, rd5, full_ff, cap);
      off5     = CW'(req.peek_index);
      peek_sum = {1'b0, rd5} + {1'b0, off5};
      peek5    = (peek_sum >= {1'b0, cap}) ? CW'(peek_sum - {1'b0, cap}) : peek_sum[CW-1:0];

      wr_n     = wr5;
      rd_n     = rd5;
      full_in  = full_ff;
      ok_in    = 1'b1;
      sel_in   = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      rd_addr5 = rd5;

      case (req.kind)
         orb_pkg::KIND_PUSH: begin
            wr_en   = 1'b1;
            // Overwrite the oldest entry when full: the read side moves along.
            if (full_ff) rd_n = adv(rd5, cap);
            wr_n    = adv(wr5, cap);
            full_in = (rd_n == wr_n);
         end
         orb_pkg::KIND_POP: begin
            if (held_now == '0) begin
               ok_in = 1'b0;
            end else begin
               rd_en   = 1'b1;
               sel_in  = 1'b1;
               rd_n    = adv(rd5, cap);
               full_in = 1'b0;
            end
         end
         orb_pkg::KIND_PEEK: begin
            if (off5 >= held_now) begin
               ok_in = 1'b0;
            end else begin
               rd_en    = 1'b1;
               sel_in   = 1'b1;
               rd_addr5 = peek5;
            end
         end
         orb_pkg::KIND_CLEAR: begin
            rd_n    = wr5;
            full_in = 1'b0;
         end
         default: begin
            ok_in = 1'b1;
         end
      endcase

      wr_ptr_in = PTR_W'(wr_n);
      rd_ptr_in = PTR_W'(rd_n);
      rd_addr   = PTR_W'(rd_addr5);
      cnt_in    = held(wr_n, rd_n, full_in, cap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         full_ff   <= 1'b0;
         cap_ff    <= orb_pkg::CAP_RESET;
      end else if (csr_we) begin
         // New capacity empties the buffer.
         cap_ff    <= csr_wdata;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         full_ff   <= 1'b0;
      end else if (cmd.exec) begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         full_ff   <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff       <= ok_in;
         sel_ff      <= sel_in;
         cnt_ff      <= cnt_in;
         full_out_ff <= full_in;
      end
   end

   assign push_wide = MW'(req.push_data);

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) mem[wr_ptr_ff] <= push_wide[DATA_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && rd_en) mem_q_ff <= mem[rd_addr];
   end

   assign rd_wide = MW'(mem_q_ff);

   assign rsp.read_data   = sel_ff ? rd_wide[BW-1:0] : '0;
   assign rsp.read_ok     = ok_ff;
   assign rsp.entry_count = cnt_ff;
   assign rsp.is_empty    = (cnt_ff == '0);
   assign rsp.is_full     = full_out_ff;

endmodule

`default_nettype wire

>>> hw/rtl/overwriting_ring_buffer.sv
// Top level of the overwriting ring buffer.
`default_nettype none

// Ring buffer whose push never blocks: on a full buffer a push replaces the
// oldest entry. Each accepted request beat (push, pop, peek or clear) yields
// one response beat in the next cycle, carrying the popped or peeked word, a
// success flag and the fill state after the operation. A new request is taken
// in the same cycle the pending response leaves, so with rsp_ready held high
// the block moves one item per cycle; the entry memory has one write port and
// one registered read port. Writing the capacity register empties the buffer
// and must happen only while no response is pending.
module overwriting_ring_buffer #(
   parameter int DEPTH      = orb_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = orb_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  orb_pkg::req_type          req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output orb_pkg::rsp_type          rsp_payload,
   input  wire                       csr_we,
   input  wire [orb_pkg::CAP_W-1:0]  csr_wdata
);

   orb_pkg::cmd_type cmd;

   orb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   orb_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req       (req_payload),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp       (rsp_payload)
   );

`ifndef SYNTHESIS
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("accepted request produced no response");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.is_empty == (rsp_payload.entry_count == '0)))
      else $error("empty flag disagrees with count");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.is_full) |-> !rsp_payload.is_empty)
      else $error("full and empty at once");

   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.read_ok) |-> (rsp_payload.read_data == '0))
      else $error("failed read returned data");
`endif

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the overwriting ring buffer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING_DEPTH    = orb_pkg::DEPTH_DEFAULT;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_OPS     = 75;

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   orb_pkg::req_type          req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   orb_pkg::rsp_type          rsp_payload;
   logic                      csr_we      = 1'b0;
   logic [orb_pkg::CAP_W-1:0] csr_wdata   = '0;

   orb_pkg::req_type ops_to_send [$];
   orb_pkg::rsp_type rsp_due [$];
   int      fail_count   = 0;
   int      quiet_cycles = 0;
   int      burst_left   = 0;
   int      gap_left     = 0;
   int      ready_hold   = 0;

   // Shadow of the ring: contents, pointers, full flag and capacity register.
   logic [orb_pkg::BEAT_W-1:0] shadow_ring [RING_DEPTH];
   int unsigned                ring_wr  = 0;
   int unsigned                ring_rd  = 0;
   bit                         ring_full = 1'b0;
   logic [orb_pkg::CAP_W-1:0]  cap_reg  = orb_pkg::CAP_RESET;

   overwriting_ring_buffer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Out-of-range capacity clamps to 1..DEPTH.
   function automatic int unsigned live_capacity();
      if (cap_reg == 0) return 1;
      if (cap_reg > RING_DEPTH) return RING_DEPTH;
      return cap_reg;
   endfunction

   function automatic int unsigned next_slot(int unsigned p, int unsigned cap);
      return (p + 1 >= cap) ? 0 : p + 1;
   endfunction

   function automatic int unsigned fill_level(int unsigned cap);
      if (ring_full) return cap;
      if (ring_wr >= ring_rd) return ring_wr - ring_rd;
      return ring_wr + cap - ring_rd;
   endfunction

   // Apply one operation to the shadow ring and return the response it yields.
   function automatic orb_pkg::rsp_type ring_apply(orb_pkg::req_type op);
      int unsigned      cap;
      int unsigned      level;
      int unsigned      slot;
      orb_pkg::rsp_type res;
      cap = live_capacity();
      res = '0;
      res.read_ok = 1'b1;
      case (op.kind)
         orb_pkg::KIND_PUSH: begin
            shadow_ring[ring_wr] = op.push_data;
            if (ring_full) ring_rd = next_slot(ring_rd, cap);
            ring_wr = next_slot(ring_wr, cap);
            ring_full = (ring_rd == ring_wr);
         end
         orb_pkg::KIND_POP: begin
            if (fill_level(cap) == 0) begin
               res.read_ok = 1'b0;
            end else begin
               res.read_data = shadow_ring[ring_rd];
               ring_rd = next_slot(ring_rd, cap);
               ring_full = 1'b0;
            end
         end
         orb_pkg::KIND_PEEK: begin
            if (int'(op.peek_index) >= fill_level(cap)) begin
               res.read_ok = 1'b0;
            end else begin
               slot = ring_rd + op.peek_index;
               if (slot >= cap) slot -= cap;
               res.read_data = shadow_ring[slot];
            end
         end
         orb_pkg::KIND_CLEAR: begin
            ring_rd = ring_wr;
            ring_full = 1'b0;
         end
         default: begin
            res.read_ok = 1'b1;
         end
      endcase
      level = fill_level(cap);
      res.entry_count = orb_pkg::CAP_W'(level);
      res.is_empty = (level == 0);
      res.is_full = ring_full;
      return res;
   endfunction

   function automatic orb_pkg::req_type make_req(orb_pkg::kind_type k,
                                                 logic [orb_pkg::BEAT_W-1:0] data,
                                                 logic [orb_pkg::PEEK_W-1:0] idx);
      orb_pkg::req_type op;
      op.kind = k;
      op.push_data = data;
      op.peek_index = idx;
      return op;
   endfunction

   function automatic void check_field(string field, logic [orb_pkg::BEAT_W-1:0] want,
                                       logic [orb_pkg::BEAT_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Return at a clock edge once nothing is queued, in flight or owed.
   task automatic wait_idle();
      do @(posedge clock);
      while (ops_to_send.size() != 0 || req_valid || rsp_due.size() != 0);
   endtask

   // Writing the capacity also empties the ring.
   task automatic program_capacity(input logic [orb_pkg::CAP_W-1:0] value);
      wait_idle();
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      cap_reg = value;
      ring_wr = 0;
      ring_rd = 0;
      ring_full = 1'b0;
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin : driver
      orb_pkg::req_type op;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready)
            rsp_due.push_back(ring_apply(req_payload));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (ops_to_send.size() > 0) begin
               op = ops_to_send.pop_front();
               req_payload <= op;
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: alternate open stretches, hard stalls and choppy ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else if (ready_hold == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               rsp_ready <= 1'b1;
               ready_hold = $urandom_range(10, 40);
            end
            1: begin
               rsp_ready <= 1'b0;
               ready_hold = $urandom_range(1, 8);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 1) == 1);
               ready_hold = $urandom_range(0, 2);
            end
         endcase
      end else begin
         ready_hold--;
      end
   end

   always @(posedge clock) begin : monitor
      orb_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            $error("response beat with nothing owed: %p", rsp_payload);
            fail_count++;
         end else begin
            want = rsp_due.pop_front();
            check_field("read_data", want.read_data, rsp_payload.read_data);
            check_field("read_ok", want.read_ok, rsp_payload.read_ok);
            check_field("entry_count", want.entry_count, rsp_payload.entry_count);
            check_field("is_empty", want.is_empty, rsp_payload.is_empty);
            check_field("is_full", want.is_full, rsp_payload.is_full);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [orb_pkg::CAP_W-1:0]  fixed_caps [6];
      int                         push_pct;
      orb_pkg::kind_type          k;
      logic [orb_pkg::PEEK_W-1:0] idx;
      fixed_caps = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd17, 5'd3};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty-buffer failures, extreme data, peek past the count, clear.
      ops_to_send.push_back(make_req(orb_pkg::KIND_POP, '0, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PEEK, '0, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_CLEAR, '1, '1));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PUSH, 32'h0000_0000, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PUSH, 32'hFFFF_FFFF, '1));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PUSH, 32'hA5A5_A5A5, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PEEK, '0, 4'd15));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PEEK, '0, 4'd2));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PEEK, '0, 4'd3));
      ops_to_send.push_back(make_req(orb_pkg::KIND_POP, '1, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_CLEAR, '0, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_POP, '0, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PUSH, 32'h5A5A_5A5A, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PEEK, '0, '0));

      // Overwrite on a full ring of two.
      program_capacity(5'd2);
      ops_to_send.push_back(make_req(orb_pkg::KIND_PUSH, 32'h0000_0001, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PUSH, 32'h0000_0002, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PUSH, 32'h0000_0003, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PEEK, '0, 4'd1));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PEEK, '0, 4'd2));
      ops_to_send.push_back(make_req(orb_pkg::KIND_POP, '0, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_POP, '0, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_POP, '0, '0));
      ops_to_send.push_back(make_req(orb_pkg::KIND_PEEK, '0, 4'd15));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_capacity(p < 6 ? fixed_caps[p]
                                : orb_pkg::CAP_W'($urandom_range(0, 31)));
         // Vary the push share so some phases run full and some run dry.
         push_pct = $urandom_range(30, 75);
         for (int n = 0; n < PHASE_OPS; n++) begin
            if ($urandom_range(0, 99) < 4) k = orb_pkg::KIND_CLEAR;
            else if ($urandom_range(0, 99) < push_pct) k = orb_pkg::KIND_PUSH;
            else if ($urandom_range(0, 1) == 1) k = orb_pkg::KIND_POP;
            else k = orb_pkg::KIND_PEEK;
            idx = ($urandom_range(0, 1) == 1) ? orb_pkg::PEEK_W'($urandom_range(0, 15))
                                              : orb_pkg::PEEK_W'($urandom_range(0, 3));
            ops_to_send.push_back(make_req(k, $urandom(), idx));
         end
      end

      wait_idle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
